@@ rtl/plbt_pkg.sv @@
// -----------------------------------------------------------------------------
// plbt_pkg
// Shared types and constants for the parallel display bus transaction core.
// -----------------------------------------------------------------------------
`default_nettype none

package plbt_pkg;

   // Request operation codes
   localparam logic [1:0] OP_BEGIN = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_END   = 2'd3;

   // Response kinds
   localparam logic [1:0] KIND_BUS_BYTE  = 2'd0;
   localparam logic [1:0] KIND_READ_WORD = 2'd1;
   localparam logic [1:0] KIND_RELEASE   = 2'd2;

   // Data formats (bit 1 selects colour conversion)
   localparam logic [1:0] FMT_BYTE = 2'd0;
   localparam logic [1:0] FMT_WORD = 2'd1;

   // Byte phases of a read word
   localparam logic [1:0] PHASE_FIRST  = 2'd0;
   localparam logic [1:0] PHASE_SECOND = 2'd1;
   localparam logic [1:0] PHASE_THIRD  = 2'd2;

   localparam bit         READ_SUPPORT = 1'b1;
   localparam logic [4:0] MAX_REPEAT   = 5'd16;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_LOAD,
      ST_EMIT
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic capture;
      logic exec;
      logic load;
   } ctrl_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic plan_empty;
   } dp_status_type;

endpackage : plbt_pkg

`default_nettype wire

@@ rtl/plbt_ctrl.sv @@
// -----------------------------------------------------------------------------
// plbt_ctrl
// Controller: takes one request, lets the datapath plan its responses, then
// steps the response sequencer one result at a time.
// -----------------------------------------------------------------------------
`default_nettype none

module plbt_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   input  plbt_pkg::dp_status_type status,
   output plbt_pkg::ctrl_cmd_type  cmd
);
   import plbt_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            state_in = status.plan_empty ? ST_IDLE : ST_EMIT;
         end
         ST_EMIT: begin
            // advance only once the held response is taken
            if (!rsp_stall && status.plan_empty) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall   = 1'b1;
      rsp_valid   = 1'b0;
      cmd.capture = 1'b0;
      cmd.exec    = 1'b0;
      cmd.load    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
         end
         ST_LOAD: begin
            cmd.load = !status.plan_empty;
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            cmd.load  = !rsp_stall && !status.plan_empty;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   a_valid_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("response pending while requests are taken");

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_EXEC))
      else $error("accepted request not executed");

   a_exec_to_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |=> (state_ff == ST_LOAD))
      else $error("execute not followed by load");

   a_load_when_taken: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !cmd.load)
      else $error("stalled response overwritten");

endmodule : plbt_ctrl

`default_nettype wire

@@ rtl/plbt_dpath.sv @@
// -----------------------------------------------------------------------------
// plbt_dpath
// Datapath: request capture, transaction state, colour conversion, read word
// assembly and the response byte sequencer with its output register.
// -----------------------------------------------------------------------------
`default_nettype none

module plbt_dpath (
   input  wire                     clock,
   input  wire                     reset,
   input  plbt_pkg::ctrl_cmd_type  cmd,
   output plbt_pkg::dp_status_type status,
   input  wire                     csr_wr_en,
   input  wire                     csr_wr_data,
   input  wire  [1:0]              req_operation,
   input  wire  [15:0]             req_command,
   input  wire                     req_command_wide,
   input  wire                     req_direction,
   input  wire  [1:0]              req_data_format,
   input  wire  [3:0]              req_dummy_count,
   input  wire  [15:0]             req_word,
   input  wire  [4:0]              req_repeat_req,
   input  wire  [7:0]              req_pin_byte,
   output logic [1:0]              rsp_kind,
   output logic                    rsp_reg_select,
   output logic [7:0]              rsp_bus_byte,
   output logic [15:0]             rsp_read_word,
   output logic                    rsp_last
);
   import plbt_pkg::*;

   // configuration
   logic        colour_order_ff;

   // captured request
   logic [1:0]  op_ff;
   logic [15:0] cmd_ff;
   logic        wide_ff;
   logic        dir_ff;
   logic [1:0]  fmt_ff;
   logic [3:0]  dum_ff;
   logic [15:0] word_ff;
   logic [4:0]  rep_ff;
   logic [7:0]  pin_ff;

   // transaction state
   logic        open_ff,  open_in;
   logic        rmode_ff, rmode_in;
   logic [1:0]  fmt_held_ff, fmt_held_in;
   logic [3:0]  dummy_left_ff, dummy_left_in;
   logic [1:0]  phase_ff, phase_in;
   logic [15:0] partial_ff, partial_in;

   // response plan
   logic [5:0]  cnt_ff, cnt_in;
   logic [1:0]  pos_ff, pos_in;
   logic [1:0]  grp_ff, grp_in;
   logic [1:0]  kind_ff, kind_in;
   logic        rs_ff, rs_in;
   logic [7:0]  b0_ff, b0_in;
   logic [7:0]  b1_ff, b1_in;
   logic [7:0]  b2_ff, b2_in;
   logic [15:0] rword_ff, rword_in;

   // output register
   logic [1:0]  out_kind_ff;
   logic        out_rs_ff;
   logic [7:0]  out_byte_ff;
   logic [15:0] out_word_ff;
   logic        out_last_ff;

   logic [4:0]  rep_sat;
   logic [7:0]  red, green, blue;
   logic [7:0]  first_b, pix_r, pix_b;
   logic [7:0]  sel_byte;
   logic [1:0]  pos_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         colour_order_ff <= 1'b0;
      end else if (csr_wr_en) begin
         colour_order_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_operation;
         cmd_ff  <= req_command;
         wide_ff <= req_command_wide;
         dir_ff  <= req_direction;
         fmt_ff  <= req_data_format;
         dum_ff  <= req_dummy_count;
         word_ff <= req_word;
         rep_ff  <= req_repeat_req;
         pin_ff  <= req_pin_byte;
      end
   end

   assign rep_sat = (rep_ff > MAX_REPEAT) ? MAX_REPEAT : rep_ff;
   assign red     = {word_ff[15:11], 3'b000};
   assign green   = {word_ff[10:5], 2'b00};
   assign blue    = {word_ff[4:0], 3'b000};
   assign first_b = partial_ff[15:8];
   assign pix_r   = colour_order_ff ? first_b : pin_ff;
   assign pix_b   = colour_order_ff ? pin_ff : first_b;

   // decode the captured request into a plan and a state update
   always_comb begin
      open_in       = open_ff;
      rmode_in      = rmode_ff;
      fmt_held_in   = fmt_held_ff;
      dummy_left_in = dummy_left_ff;
      phase_in      = phase_ff;
      partial_in    = partial_ff;
      cnt_in        = 6'd0;
      pos_in        = 2'd0;
      grp_in        = 2'd1;
      kind_in       = KIND_BUS_BYTE;
      rs_in         = 1'b0;
      b0_in         = 8'd0;
      b1_in         = 8'd0;
      b2_in         = 8'd0;
      rword_in      = 16'd0;
      case (op_ff)
         OP_BEGIN: begin
            if (!open_ff && !(dir_ff && !READ_SUPPORT)) begin
               if (wide_ff) begin
                  cnt_in = 6'd2;
                  grp_in = 2'd2;
                  b0_in  = cmd_ff[15:8];
                  b1_in  = cmd_ff[7:0];
               end else begin
                  cnt_in = 6'd1;
                  b0_in  = cmd_ff[7:0];
               end
               open_in       = 1'b1;
               rmode_in      = dir_ff;
               fmt_held_in   = fmt_ff;
               dummy_left_in = dum_ff;
               phase_in      = PHASE_FIRST;
               partial_in    = 16'd0;
            end
         end
         OP_WRITE: begin
            if (open_ff && !rmode_ff) begin
               rs_in = 1'b1;
               if (fmt_held_ff[1]) begin
                  grp_in = 2'd3;
                  cnt_in = {1'b0, rep_sat} + {rep_sat, 1'b0};
                  b0_in  = colour_order_ff ? red : blue;
                  b1_in  = green;
                  b2_in  = colour_order_ff ? blue : red;
               end else if (fmt_held_ff == FMT_WORD) begin
                  grp_in = 2'd2;
                  cnt_in = {rep_sat, 1'b0};
                  b0_in  = word_ff[15:8];
                  b1_in  = word_ff[7:0];
               end else begin
                  cnt_in = {1'b0, rep_sat};
                  b0_in  = word_ff[7:0];
               end
            end
         end
         OP_READ: begin
            if (open_ff && rmode_ff && READ_SUPPORT) begin
               kind_in = KIND_READ_WORD;
               rs_in   = 1'b1;
               if (dummy_left_ff != 4'd0) begin
                  // drop a dummy byte
                  dummy_left_in = dummy_left_ff - 4'd1;
               end else if (fmt_held_ff[1]) begin
                  if (phase_ff == PHASE_FIRST) begin
                     partial_in = {pin_ff, 8'd0};
                     phase_in   = PHASE_SECOND;
                  end else if (phase_ff == PHASE_SECOND) begin
                     partial_in = {partial_ff[15:8], pin_ff};
                     phase_in   = PHASE_THIRD;
                  end else begin
                     cnt_in     = 6'd1;
                     rword_in   = {pix_r[7:3], partial_ff[7:2], pix_b[7:3]};
                     phase_in   = PHASE_FIRST;
                     partial_in = 16'd0;
                  end
               end else if (fmt_held_ff == FMT_WORD) begin
                  if (phase_ff == PHASE_FIRST) begin
                     partial_in = {pin_ff, 8'd0};
                     phase_in   = PHASE_SECOND;
                  end else begin
                     cnt_in     = 6'd1;
                     rword_in   = {partial_ff[15:8], pin_ff};
                     phase_in   = PHASE_FIRST;
                     partial_in = 16'd0;
                  end
               end else begin
                  cnt_in   = 6'd1;
                  rword_in = {8'd0, pin_ff};
               end
            end
         end
         OP_END: begin
            if (open_ff) begin
               cnt_in        = 6'd1;
               kind_in       = KIND_RELEASE;
               open_in       = 1'b0;
               rmode_in      = 1'b0;
               fmt_held_in   = FMT_BYTE;
               dummy_left_in = 4'd0;
               phase_in      = PHASE_FIRST;
               partial_in    = 16'd0;
            end
         end
         default: begin
            cnt_in = 6'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff       <= 1'b0;
         rmode_ff      <= 1'b0;
         fmt_held_ff   <= FMT_BYTE;
         dummy_left_ff <= 4'd0;
         phase_ff      <= PHASE_FIRST;
         partial_ff    <= 16'd0;
      end else if (cmd.exec) begin
         open_ff       <= open_in;
         rmode_ff      <= rmode_in;
         fmt_held_ff   <= fmt_held_in;
         dummy_left_ff <= dummy_left_in;
         phase_ff      <= phase_in;
         partial_ff    <= partial_in;
      end
   end

   assign sel_byte = (pos_ff == 2'd0) ? b0_ff :
                     (pos_ff == 2'd1) ? b1_ff : b2_ff;
   assign pos_next = (pos_ff + 2'd1 == grp_ff) ? 2'd0 : pos_ff + 2'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 6'd0;
         pos_ff <= 2'd0;
      end else if (cmd.exec) begin
         cnt_ff <= cnt_in;
         pos_ff <= pos_in;
      end else if (cmd.load) begin
         cnt_ff <= cnt_ff - 6'd1;
         pos_ff <= pos_next;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         grp_ff   <= grp_in;
         kind_ff  <= kind_in;
         rs_ff    <= rs_in;
         b0_ff    <= b0_in;
         b1_ff    <= b1_in;
         b2_ff    <= b2_in;
         rword_ff <= rword_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         out_kind_ff <= kind_ff;
         out_rs_ff   <= rs_ff;
         out_byte_ff <= (kind_ff == KIND_BUS_BYTE) ? sel_byte : 8'd0;
         out_word_ff <= rword_ff;
         out_last_ff <= (cnt_ff == 6'd1);
      end
   end

   assign status.plan_empty = (cnt_ff == 6'd0);

   assign rsp_kind       = out_kind_ff;
   assign rsp_reg_select = out_rs_ff;
   assign rsp_bus_byte   = out_byte_ff;
   assign rsp_read_word  = out_word_ff;
   assign rsp_last       = out_last_ff;

   a_plan_bounded: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 6'd48)
      else $error("response plan longer than the largest fill");

   a_pos_in_group: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != 6'd0) |-> (pos_ff < grp_ff))
      else $error("byte position outside its group");

   a_release_closes: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && op_ff == OP_END) |=> !open_ff)
      else $error("end request left the transaction open");

endmodule : plbt_dpath

`default_nettype wire

@@ rtl/parallel_lcd_bus_transaction_core.sv @@
// -----------------------------------------------------------------------------
// parallel_lcd_bus_transaction_core
// Request sequencer for an 8-bit 8080-style parallel display bus.
// -----------------------------------------------------------------------------
// One request is handled at a time. It is taken in the idle state, decoded
// and applied to the transaction state in the execute state, and its first
// response is loaded into the output register in the load state (a request
// with no response returns to idle instead); responses then follow one per
// cycle while rsp_stall is low: begin gives one or two command bytes, a write
// gives up to 48 bus bytes (16 repeats of a three-byte colour pixel), a read
// gives zero or one word, an end gives one release. The byte sequencer sets
// the rate; req_stall stays high until the last response has been taken.
`default_nettype none

module parallel_lcd_bus_transaction_core (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_wr_en,
   input  wire         csr_wr_data,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [1:0]  req_operation,
   input  wire  [15:0] req_command,
   input  wire         req_command_wide,
   input  wire         req_direction,
   input  wire  [1:0]  req_data_format,
   input  wire  [3:0]  req_dummy_count,
   input  wire  [15:0] req_word,
   input  wire  [4:0]  req_repeat_req,
   input  wire  [7:0]  req_pin_byte,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic        rsp_reg_select,
   output logic [7:0]  rsp_bus_byte,
   output logic [15:0] rsp_read_word,
   output logic        rsp_last
);
   import plbt_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   plbt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   plbt_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_operation    (req_operation),
      .req_command      (req_command),
      .req_command_wide (req_command_wide),
      .req_direction    (req_direction),
      .req_data_format  (req_data_format),
      .req_dummy_count  (req_dummy_count),
      .req_word         (req_word),
      .req_repeat_req   (req_repeat_req),
      .req_pin_byte     (req_pin_byte),
      .rsp_kind         (rsp_kind),
      .rsp_reg_select   (rsp_reg_select),
      .rsp_bus_byte     (rsp_bus_byte),
      .rsp_read_word    (rsp_read_word),
      .rsp_last         (rsp_last)
   );

endmodule : parallel_lcd_bus_transaction_core

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb
// Self-checking bench for the parallel display bus transaction core.
// -----------------------------------------------------------------------------
// Requests go in through one shared send task. A bus model updated at each
// accepted request lists the bus bytes, read words and releases it must
// cause. A checker process compares every accepted response with the oldest
// expectation. Directed tests cover the formats, the colour order and the
// ignored requests. Back-pressure and random transaction traffic follow.
// -----------------------------------------------------------------------------

module tb;
   import plbt_pkg::*;

   localparam logic [1:0]  FMT_COLOUR      = 2'd2;
   localparam logic [1:0]  FMT_COLOUR_ALT  = 2'd3;
   localparam logic [1:0]  RX_FREE         = 2'd0;
   localparam logic [1:0]  RX_RANDOM       = 2'd1;
   localparam logic [1:0]  RX_PATTERN      = 2'd2;
   localparam int unsigned HOLD_OFF_CYCLES = 300;
   localparam int unsigned SETTLE_CYCLES   = 8;
   localparam int unsigned SETTLE_LIMIT    = 20000;
   localparam int unsigned CYCLE_LIMIT     = 400000;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] command;
      logic        command_wide;
      logic        direction;
      logic [1:0]  data_format;
      logic [3:0]  dummy_count;
      logic [15:0] word;
      logic [4:0]  repeat_req;
      logic [7:0]  pin_byte;
   } bus_request_t;

   typedef struct packed {
      logic [1:0]  kind;
      logic        reg_select;
      logic [7:0]  bus_byte;
      logic [15:0] read_word;
      logic        last;
   } bus_event_t;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        csr_wr_en      = 1'b0;
   logic        csr_wr_data    = 1'b0;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [1:0]  req_operation  = OP_END;
   logic [15:0] req_command    = '0;
   logic        req_command_wide = 1'b0;
   logic        req_direction  = 1'b0;
   logic [1:0]  req_data_format = FMT_BYTE;
   logic [3:0]  req_dummy_count = '0;
   logic [15:0] req_word       = '0;
   logic [4:0]  req_repeat_req = 5'd1;
   logic [7:0]  req_pin_byte   = '0;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic [1:0]  rsp_kind;
   logic        rsp_reg_select;
   logic [7:0]  rsp_bus_byte;
   logic [15:0] rsp_read_word;
   logic        rsp_last;

   // bus model state
   logic        colour_order_model = 1'b0;
   logic        model_open    = 1'b0;
   logic        model_read    = 1'b0;
   logic [1:0]  model_format  = FMT_BYTE;
   logic [3:0]  model_dummies = '0;
   logic [1:0]  model_phase   = PHASE_FIRST;
   logic [15:0] model_partial = '0;

   bus_event_t  expected_bus_events[$];
   bus_event_t  got_event, want_event;
   int unsigned events_made;
   int unsigned issued_count    = 0;
   int unsigned mismatch_count  = 0;
   int unsigned cycle_count     = 0;

   // stimulus pacing
   logic        tx_bursts        = 1'b1;
   int unsigned burst_left       = 0;
   logic [1:0]  rx_mode          = RX_RANDOM;
   int unsigned rx_phase         = 0;
   logic        hold_off_pending = 1'b0;
   int unsigned hold_left        = 0;

   parallel_lcd_bus_transaction_core dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_command      (req_command),
      .req_command_wide (req_command_wide),
      .req_direction    (req_direction),
      .req_data_format  (req_data_format),
      .req_dummy_count  (req_dummy_count),
      .req_word         (req_word),
      .req_repeat_req   (req_repeat_req),
      .req_pin_byte     (req_pin_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_reg_select   (rsp_reg_select),
      .rsp_bus_byte     (rsp_bus_byte),
      .rsp_read_word    (rsp_read_word),
      .rsp_last         (rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("simulation failed");
         $finish;
      end
   end

   // receiver: own stall pattern, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_off_pending) begin
         hold_off_pending = 1'b0;
         hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left != 0) begin
         rsp_stall = 1'b1;
         hold_left--;
      end else begin
         case (rx_mode)
            RX_RANDOM:  rsp_stall = ($urandom_range(0, 2) == 0);
            RX_PATTERN: rsp_stall = (rx_phase == 1 || rx_phase == 2 || rx_phase == 5);
            default:    rsp_stall = 1'b0;
         endcase
      end
      rx_phase = (rx_phase == 6) ? 0 : rx_phase + 1;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got_event.kind       = rsp_kind;
         got_event.reg_select = rsp_reg_select;
         got_event.bus_byte   = rsp_bus_byte;
         got_event.read_word  = rsp_read_word;
         got_event.last       = rsp_last;
         if (expected_bus_events.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response: kind %0d rs %0d byte %02h word %04h last %0d",
                        got_event.kind, got_event.reg_select, got_event.bus_byte,
                        got_event.read_word, got_event.last);
         end else begin
            want_event = expected_bus_events.pop_front();
            if (got_event.kind !== want_event.kind ||
                got_event.reg_select !== want_event.reg_select ||
                got_event.bus_byte !== want_event.bus_byte ||
                got_event.read_word !== want_event.read_word ||
                got_event.last !== want_event.last) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $write("mismatch: expected kind %0d rs %0d byte %02h word %04h last %0d,",
                         want_event.kind, want_event.reg_select, want_event.bus_byte,
                         want_event.read_word, want_event.last);
                  $display(" got kind %0d rs %0d byte %02h word %04h last %0d",
                           got_event.kind, got_event.reg_select, got_event.bus_byte,
                           got_event.read_word, got_event.last);
               end
            end
         end
      end
   end

   task note_event(input logic [1:0] kind, input logic rs, input logic [7:0] data_byte,
                   input logic [15:0] data_word);
      bus_event_t e;
      e.kind       = kind;
      e.reg_select = rs;
      e.bus_byte   = data_byte;
      e.read_word  = data_word;
      e.last       = 1'b0;
      expected_bus_events.push_back(e);
      events_made++;
   endtask

   task predict_bus_events(input bus_request_t r);
      logic [4:0]  reps;
      logic [7:0]  red, green, blue, held_first, held_second;
      logic [15:0] pixel;
      bus_event_t  tail;
      events_made = 0;
      case (r.operation)
         OP_BEGIN: begin
            if (!model_open && !(r.direction && !READ_SUPPORT)) begin
               if (r.command_wide)
                  note_event(KIND_BUS_BYTE, 1'b0, r.command[15:8], '0);
               note_event(KIND_BUS_BYTE, 1'b0, r.command[7:0], '0);
               model_open    = 1'b1;
               model_read    = r.direction;
               model_format  = r.data_format;
               model_dummies = r.dummy_count;
               model_phase   = PHASE_FIRST;
               model_partial = '0;
            end
         end
         OP_WRITE: begin
            if (model_open && !model_read) begin
               reps  = (r.repeat_req > MAX_REPEAT) ? MAX_REPEAT : r.repeat_req;
               red   = {r.word[15:11], 3'b000};
               green = {r.word[10:5], 2'b00};
               blue  = {r.word[4:0], 3'b000};
               repeat (reps) begin
                  if (model_format[1]) begin
                     note_event(KIND_BUS_BYTE, 1'b1, colour_order_model ? red : blue, '0);
                     note_event(KIND_BUS_BYTE, 1'b1, green, '0);
                     note_event(KIND_BUS_BYTE, 1'b1, colour_order_model ? blue : red, '0);
                  end else if (model_format == FMT_WORD) begin
                     note_event(KIND_BUS_BYTE, 1'b1, r.word[15:8], '0);
                     note_event(KIND_BUS_BYTE, 1'b1, r.word[7:0], '0);
                  end else begin
                     note_event(KIND_BUS_BYTE, 1'b1, r.word[7:0], '0);
                  end
               end
            end
         end
         OP_READ: begin
            if (model_open && model_read && READ_SUPPORT) begin
               if (model_dummies != 0) begin
                  model_dummies = model_dummies - 4'd1;
               end else if (model_format[1]) begin
                  case (model_phase)
                     PHASE_FIRST: begin
                        model_partial = {r.pin_byte, 8'h00};
                        model_phase   = PHASE_SECOND;
                     end
                     PHASE_SECOND: begin
                        model_partial[7:0] = r.pin_byte;
                        model_phase        = PHASE_THIRD;
                     end
                     default: begin
                        held_first  = model_partial[15:8];
                        held_second = model_partial[7:0];
                        red   = colour_order_model ? held_first : r.pin_byte;
                        blue  = colour_order_model ? r.pin_byte : held_first;
                        pixel = {red[7:3], held_second[7:2], blue[7:3]};
                        note_event(KIND_READ_WORD, 1'b1, '0, pixel);
                        model_phase   = PHASE_FIRST;
                        model_partial = '0;
                     end
                  endcase
               end else if (model_format == FMT_WORD) begin
                  if (model_phase == PHASE_FIRST) begin
                     model_partial = {r.pin_byte, 8'h00};
                     model_phase   = PHASE_SECOND;
                  end else begin
                     note_event(KIND_READ_WORD, 1'b1, '0, {model_partial[15:8], r.pin_byte});
                     model_phase   = PHASE_FIRST;
                     model_partial = '0;
                  end
               end else begin
                  note_event(KIND_READ_WORD, 1'b1, '0, {8'h00, r.pin_byte});
               end
            end
         end
         default: begin
            if (model_open) begin
               note_event(KIND_RELEASE, 1'b0, '0, '0);
               model_open    = 1'b0;
               model_read    = 1'b0;
               model_format  = FMT_BYTE;
               model_dummies = '0;
               model_phase   = PHASE_FIRST;
               model_partial = '0;
            end
         end
      endcase
      if (events_made != 0) begin
         tail = expected_bus_events.pop_back();
         tail.last = 1'b1;
         expected_bus_events.push_back(tail);
      end
   endtask

   function automatic bus_request_t random_request();
      bus_request_t r;
      r.operation    = 2'($urandom_range(0, 3));
      r.command      = 16'($urandom);
      r.command_wide = 1'($urandom_range(0, 1));
      r.direction    = 1'($urandom_range(0, 1));
      r.data_format  = 2'($urandom_range(0, 3));
      r.dummy_count  = 4'($urandom);
      r.word         = 16'($urandom);
      r.repeat_req   = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                   : 5'($urandom_range(0, 4));
      r.pin_byte     = 8'($urandom);
      return r;
   endfunction

   function automatic bus_request_t make_begin(input logic [15:0] cmd, input logic wide,
                                               input logic dir, input logic [1:0] fmt,
                                               input logic [3:0] dummies);
      bus_request_t r;
      r = random_request();
      r.operation    = OP_BEGIN;
      r.command      = cmd;
      r.command_wide = wide;
      r.direction    = dir;
      r.data_format  = fmt;
      r.dummy_count  = dummies;
      return r;
   endfunction

   function automatic bus_request_t make_write(input logic [15:0] w, input logic [4:0] reps);
      bus_request_t r;
      r = random_request();
      r.operation  = OP_WRITE;
      r.word       = w;
      r.repeat_req = reps;
      return r;
   endfunction

   function automatic bus_request_t make_read(input logic [7:0] pin);
      bus_request_t r;
      r = random_request();
      r.operation = OP_READ;
      r.pin_byte  = pin;
      return r;
   endfunction

   function automatic bus_request_t make_end();
      bus_request_t r;
      r = random_request();
      r.operation = OP_END;
      return r;
   endfunction

   // send one request, idling between bursts when enabled
   task issue(input bus_request_t r);
      if (tx_bursts && burst_left == 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat ($urandom_range(0, 5)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      if (burst_left != 0)
         burst_left--;
      @(negedge clock);
      req_operation    = r.operation;
      req_command      = r.command;
      req_command_wide = r.command_wide;
      req_direction    = r.direction;
      req_data_format  = r.data_format;
      req_dummy_count  = r.dummy_count;
      req_word         = r.word;
      req_repeat_req   = r.repeat_req;
      req_pin_byte     = r.pin_byte;
      req_valid        = 1'b1;
      do @(posedge clock); while (req_stall);
      predict_bus_events(r);
      issued_count++;
   endtask

   // stop sending and wait for every outstanding response
   task settle_bus();
      int unsigned waited;
      waited = 0;
      @(negedge clock);
      req_valid  = 1'b0;
      burst_left = 0;
      while (expected_bus_events.size() != 0 && waited < SETTLE_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task set_colour_order(input logic order);
      settle_bus();
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = order;
      @(posedge clock);
      colour_order_model = order;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task test_write_formats();
      set_colour_order(1'b0);
      rx_mode   = RX_RANDOM;
      tx_bursts = 1'b1;
      issue(make_begin(16'h002C, 1'b0, 1'b0, FMT_BYTE, 4'd0));
      issue(make_write(16'hFFFF, 5'd1));
      issue(make_write(16'h0000, 5'd0));
      issue(make_write(16'h12A5, 5'd31));
      issue(make_begin(16'hFFFF, 1'b1, 1'b1, FMT_WORD, 4'd15));
      issue(make_read(8'hFF));
      issue(make_end());
      issue(make_end());
      issue(make_write(16'hFFFF, 5'd1));
      issue(make_begin(16'hFFFF, 1'b1, 1'b0, FMT_WORD, 4'd0));
      issue(make_write(16'hA55A, 5'd2));
      issue(make_end());
   endtask

   task test_colour_conversion();
      set_colour_order(1'b1);
      issue(make_begin(16'h0000, 1'b1, 1'b0, FMT_COLOUR, 4'd0));
      issue(make_write(16'hF81F, MAX_REPEAT));
      issue(make_write(16'h07E0, 5'd1));
      issue(make_end());
   endtask

   task test_read_assembly();
      set_colour_order(1'b0);
      issue(make_begin(16'h00DA, 1'b0, 1'b1, FMT_BYTE, 4'd0));
      issue(make_read(8'hFF));
      issue(make_read(8'h00));
      issue(make_write(16'h1234, 5'd1));
      issue(make_end());
      // word read: one dummy, one whole word, then end on a held byte
      issue(make_begin(16'h0D0A, 1'b1, 1'b1, FMT_WORD, 4'd1));
      issue(make_read(8'h5A));
      issue(make_read(8'hAB));
      issue(make_read(8'hCD));
      issue(make_read(8'hEF));
      issue(make_end());
      set_colour_order(1'b1);
      issue(make_begin(16'h002E, 1'b0, 1'b1, FMT_COLOUR_ALT, 4'd0));
      issue(make_read(8'hF8));
      issue(make_read(8'hFC));
      issue(make_read(8'h07));
      issue(make_end());
   endtask

   task test_backpressure();
      set_colour_order(1'b0);
      rx_mode   = RX_RANDOM;
      tx_bursts = 1'b0;
      issue(make_begin(16'h2C2C, 1'b1, 1'b0, FMT_COLOUR, 4'd0));
      hold_off_pending = 1'b1;
      repeat (6) issue(make_write(16'($urandom), MAX_REPEAT));
      // pause the sender until the backlog has drained
      settle_bus();
      issue(make_write(16'($urandom), 5'd2));
      issue(make_end());
   endtask

   function automatic logic [3:0] pick_dummies();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll < 6)
         return 4'd0;
      else if (roll < 9)
         return 4'($urandom_range(1, 3));
      return 4'($urandom_range(0, 15));
   endfunction

   function automatic logic [4:0] pick_repeat();
      if ($urandom_range(0, 9) == 0)
         return 5'($urandom_range(0, 31));
      return 5'($urandom_range(1, 4));
   endfunction

   task run_random_traffic(input int unsigned target);
      int unsigned start, body;
      logic        dir;
      logic [3:0]  dummies;
      start = issued_count;
      while (issued_count - start < target) begin
         if ($urandom_range(0, 6) == 0) begin
            issue(random_request());
         end else begin
            dir     = 1'($urandom_range(0, 1));
            dummies = pick_dummies();
            issue(make_begin(16'($urandom), 1'($urandom_range(0, 1)), dir,
                             2'($urandom_range(0, 3)), dummies));
            body = dir ? dummies + $urandom_range(1, 9) : $urandom_range(1, 8);
            repeat (body) begin
               if ($urandom_range(0, 11) == 0)
                  issue(random_request());
               else if (dir)
                  issue(make_read(8'($urandom)));
               else
                  issue(make_write(16'($urandom), pick_repeat()));
            end
            if ($urandom_range(0, 9) != 0)
               issue(make_end());
         end
      end
   endtask

   task test_random_traffic();
      set_colour_order(1'b0);
      rx_mode   = RX_RANDOM;
      tx_bursts = 1'b1;
      run_random_traffic(70);
      set_colour_order(1'b1);
      rx_mode   = RX_PATTERN;
      tx_bursts = 1'b0;
      run_random_traffic(70);
      set_colour_order(1'b0);
      rx_mode   = RX_FREE;
      run_random_traffic(70);
      set_colour_order(1'b1);
      rx_mode   = RX_RANDOM;
      tx_bursts = 1'b1;
      run_random_traffic(70);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_write_formats();
      test_colour_conversion();
      test_read_assembly();
      test_backpressure();
      test_random_traffic();
      settle_bus();
      if (expected_bus_events.size() != 0) begin
         mismatch_count += expected_bus_events.size();
         $display("%0d expected responses never arrived", expected_bus_events.size());
      end
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
